// ===== rtl/c2dc_pkg.sv =====
package c2dc_pkg;

   // geometry limits
   localparam int MaxWidth   = 1024;
   localparam int MaxHeight  = 1024;
   localparam int KernelSize = 3;

   // field and register widths
   localparam int PixW     = 8;
   localparam int PixMax   = 255;
   localparam int GeomW    = 11;
   localparam int CoefW    = 16;
   localparam int CoefRowW = 3 * CoefW;
   localparam int ShiftW   = 4;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = CoefRowW;

   // column counter indexes the line stores; CntW also holds the clamped width
   localparam int ColW = $clog2(MaxWidth);
   localparam int CntW = (ColW + 1 > GeomW) ? ColW + 1 : GeomW;

   // reset values of the geometry registers
   localparam int WidthReset  = 640;
   localparam int HeightReset = 480;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_IMAGE_WIDTH     = 3'd0,
      CSR_IMAGE_HEIGHT    = 3'd1,
      CSR_COEF_TOP_ROW    = 3'd2,
      CSR_COEF_MID_ROW    = 3'd3,
      CSR_COEF_BOTTOM_ROW = 3'd4,
      CSR_FRAC_SHIFT      = 3'd5
   } csr_index_type;

   typedef logic [PixW-1:0] pix_type;

   // [row][col]: row 0 is two lines up, col 0 is the left neighbor
   typedef pix_type [2:0][2:0] window_type;

   typedef logic [2:0][CoefRowW-1:0] coef_type;

   // per-item control decoded from the position counters at accept time
   typedef struct packed {
      logic x_zero;    // first column: closes the previous row on the right edge
      logic up1_ok;    // line above exists
      logic up2_ok;    // line two above exists
      logic pix_zero;  // fill item or row past the frame
      logic emit;      // item gives a result
      logic last;      // result is the final pixel of the frame
      logic fwd;       // line store data comes from the item just ahead
   } item_ctl_type;

endpackage

// ===== rtl/c2dc_req_if.sv =====
interface c2dc_req_if;
   logic                  valid;
   logic                  ready;
   logic [c2dc_pkg::PixW-1:0] pixel_in;
   logic                  fill;

   modport source (output valid, output pixel_in, output fill, input ready);
   modport sink   (input valid, input pixel_in, input fill, output ready);
endinterface

// ===== rtl/c2dc_rsp_if.sv =====
interface c2dc_rsp_if;
   logic                  valid;
   logic                  ready;
   logic [c2dc_pkg::PixW-1:0] pixel_out;
   logic                  frame_last;

   modport source (output valid, output pixel_out, output frame_last, input ready);
   modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

// ===== rtl/c2dc_ram.sv =====
module c2dc_ram #(
   parameter int Width = 8,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/c2dc_kernel.sv =====
module c2dc_kernel (
   input  c2dc_pkg::window_type             win,
   input  c2dc_pkg::coef_type               coef,
   input  logic [c2dc_pkg::ShiftW-1:0]      shift,
   output logic [c2dc_pkg::PixW-1:0]        result
);

   localparam int Half  = c2dc_pkg::KernelSize / 2;
   localparam int ProdW = c2dc_pkg::PixW + c2dc_pkg::CoefW + 1;
   localparam int SumW  = ProdW + 4;

   logic signed [SumW-1:0] sum;
   logic        [SumW-1:0] scaled;

   // nine independent products into one adder tree
   always_comb begin
      logic signed [ProdW-1:0] prod;
      sum  = '0;
      prod = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if ((r - 1) <= Half && (1 - r) <= Half && (c - 1) <= Half && (1 - c) <= Half) begin
               prod = $signed({1'b0, win[r][c]})
                    * $signed(coef[r][c*c2dc_pkg::CoefW +: c2dc_pkg::CoefW]);
               sum  = sum + SumW'(prod);
            end
         end
      end
   end

   // shift only matters for a positive sum
   always_comb begin
      scaled = $unsigned(sum) >> shift;
      if (sum <= 0) begin
         result = '0;
      end else if (scaled > SumW'(c2dc_pkg::PixMax)) begin
         result = c2dc_pkg::PixW'(c2dc_pkg::PixMax);
      end else begin
         result = scaled[c2dc_pkg::PixW-1:0];
      end
   end

endmodule

// ===== rtl/clamped_2d_convolution.sv =====
// channel   role    handshake      payload
// req_chan  input   valid/ready    pixel_in[7:0], fill
// rsp_chan  output  valid/ready    pixel_out[7:0], frame_last
// csr_*     config  csr_wr_en      csr_index[2:0], csr_wr_data[47:0]
//
// One item per clock sustained unless results stall. An item's line store
// data lands in the input stage, and its result is registered in the output
// register as it leaves; a frame's first result comes from the item one row
// plus one item after its first. Reset is synchronous: counters, window and
// valids clear, line stores are not cleared (rows above the first are gated
// to zero). A stalled result holds the input stage only if its item gives one.
module clamped_2d_convolution (
   input  logic                               clock,
   input  logic                               reset,
   c2dc_req_if.sink                           req_chan,
   c2dc_rsp_if.source                         rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [c2dc_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [c2dc_pkg::CsrDataW-1:0]      csr_wr_data
);

   localparam int ColW  = c2dc_pkg::ColW;
   localparam int CntW  = c2dc_pkg::CntW;
   localparam int GeomW = c2dc_pkg::GeomW;
   localparam int PixW  = c2dc_pkg::PixW;

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [GeomW-1:0]            width_ff;
   logic [GeomW-1:0]            height_ff;
   c2dc_pkg::coef_type          coef_ff;
   logic [c2dc_pkg::ShiftW-1:0] shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= GeomW'(c2dc_pkg::WidthReset);
         height_ff <= GeomW'(c2dc_pkg::HeightReset);
         coef_ff   <= '0;
         shift_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (c2dc_pkg::csr_index_type'(csr_index))
            c2dc_pkg::CSR_IMAGE_WIDTH:     width_ff   <= csr_wr_data[GeomW-1:0];
            c2dc_pkg::CSR_IMAGE_HEIGHT:    height_ff  <= csr_wr_data[GeomW-1:0];
            c2dc_pkg::CSR_COEF_TOP_ROW:    coef_ff[0] <= csr_wr_data;
            c2dc_pkg::CSR_COEF_MID_ROW:    coef_ff[1] <= csr_wr_data;
            c2dc_pkg::CSR_COEF_BOTTOM_ROW: coef_ff[2] <= csr_wr_data;
            c2dc_pkg::CSR_FRAC_SHIFT:      shift_ff   <= csr_wr_data[c2dc_pkg::ShiftW-1:0];
            default: begin
            end
         endcase
      end
   end

   // out-of-range geometry: zero acts as one, oversize acts as the maximum
   logic [CntW-1:0]  w_eff;
   logic [GeomW-1:0] h_eff;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = CntW'(1);
      end else if (CntW'(width_ff) > CntW'(c2dc_pkg::MaxWidth)) begin
         w_eff = CntW'(c2dc_pkg::MaxWidth);
      end else begin
         w_eff = CntW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = GeomW'(1);
      end else if (height_ff > GeomW'(c2dc_pkg::MaxHeight)) begin
         h_eff = GeomW'(c2dc_pkg::MaxHeight);
      end else begin
         h_eff = height_ff;
      end
   end

   // ---------------------------------------------------------------------
   // handshake
   // ---------------------------------------------------------------------
   logic                  s1_v_ff, s1_v_in;
   c2dc_pkg::item_ctl_type s1_ctl_ff, ctl_in;
   logic [PixW-1:0]       s1_pix_ff;
   logic [ColW-1:0]       s1_addr_ff;
   logic [PixW-1:0]       s1_fwd_a_ff, s1_fwd_b_ff;
   logic                  out_v_ff, out_v_in;
   logic [PixW-1:0]       out_pix_ff;
   logic                  out_last_ff;

   logic req_acc;
   logic out_free;
   logic s1_adv;

   assign out_free       = !out_v_ff || rsp_chan.ready;
   assign s1_adv         = s1_v_ff && (!s1_ctl_ff.emit || out_free);
   assign req_chan.ready = !s1_v_ff || s1_adv;
   assign req_acc        = req_chan.valid && req_chan.ready;

   // ---------------------------------------------------------------------
   // position counters: next item's column and row in the extended stream
   // ---------------------------------------------------------------------
   logic [ColW-1:0]  col_ff, col_in;
   logic [GeomW-1:0] row_ff, row_in;
   logic [CntW-1:0]  col_next;

   always_comb begin
      col_next = CntW'(col_ff) + CntW'(1);

      ctl_in.x_zero   = (col_ff == '0);
      ctl_in.up1_ok   = (row_ff != '0);
      ctl_in.up2_ok   = (row_ff >= GeomW'(2));
      ctl_in.pix_zero = req_chan.fill || (row_ff >= h_eff);
      // first column closes the row two above the current one
      if (ctl_in.x_zero) begin
         ctl_in.emit = ctl_in.up2_ok && ((row_ff - GeomW'(2)) < h_eff);
      end else begin
         ctl_in.emit = ctl_in.up1_ok && ((row_ff - GeomW'(1)) < h_eff);
      end
      ctl_in.last = ctl_in.x_zero && ctl_in.up2_ok
                 && ((row_ff - GeomW'(2)) == (h_eff - GeomW'(1)));
      // the item ahead writes this address in the same cycle as our read
      ctl_in.fwd  = s1_v_ff && s1_adv && (s1_addr_ff == col_ff);

      if (ctl_in.last) begin
         col_in = '0;
         row_in = '0;
      end else if (col_next >= w_eff) begin
         col_in = '0;
         row_in = row_ff + GeomW'(1);
      end else begin
         col_in = col_next[ColW-1:0];
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_acc) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------------
   // line stores: read at accept, written when the item leaves stage 1
   // ---------------------------------------------------------------------
   logic [PixW-1:0] ram_a_q, ram_b_q;
   logic [PixW-1:0] up1, up2, pix_w;
   logic [PixW-1:0] rd_a, rd_b;

   assign pix_w = s1_ctl_ff.pix_zero ? '0 : s1_pix_ff;
   assign rd_a  = s1_ctl_ff.fwd ? s1_fwd_a_ff : ram_a_q;
   assign rd_b  = s1_ctl_ff.fwd ? s1_fwd_b_ff : ram_b_q;
   assign up1   = s1_ctl_ff.up1_ok ? rd_a : '0;
   assign up2   = s1_ctl_ff.up2_ok ? rd_b : '0;

   c2dc_ram #(.Width(PixW), .Depth(c2dc_pkg::MaxWidth)) u_line_a (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_addr_ff),
      .wr_data (pix_w),
      .rd_en   (req_acc),
      .rd_addr (col_ff),
      .rd_data (ram_a_q)
   );

   c2dc_ram #(.Width(PixW), .Depth(c2dc_pkg::MaxWidth)) u_line_b (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_addr_ff),
      .wr_data (up1),
      .rd_en   (req_acc),
      .rd_addr (col_ff),
      .rd_data (ram_b_q)
   );

   // ---------------------------------------------------------------------
   // input stage
   // ---------------------------------------------------------------------
   always_comb begin
      if (req_acc) begin
         s1_v_in = 1'b1;
      end else if (s1_adv) begin
         s1_v_in = 1'b0;
      end else begin
         s1_v_in = s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_ctl_ff   <= ctl_in;
         s1_pix_ff   <= req_chan.pixel_in;
         s1_addr_ff  <= col_ff;
         s1_fwd_a_ff <= pix_w;
         s1_fwd_b_ff <= up1;
      end
   end

   // ---------------------------------------------------------------------
   // window: only the two rightmost columns persist; the oldest column of the
   // model's window is never read again
   // ---------------------------------------------------------------------
   logic [2:0][PixW-1:0] win1_ff, win1_in;
   logic [2:0][PixW-1:0] win2_ff, win2_in;
   logic [2:0][PixW-1:0] new_col;
   c2dc_pkg::window_type kwin;
   logic [PixW-1:0]      k_result;

   assign new_col = {pix_w, up1, up2};

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         kwin[r][0] = win1_ff[r];
         kwin[r][1] = win2_ff[r];
         // right edge of the previous row pads with zero
         kwin[r][2] = s1_ctl_ff.x_zero ? '0 : new_col[r];
      end

      if (s1_ctl_ff.last) begin
         win1_in = '0;
         win2_in = '0;
      end else if (s1_ctl_ff.x_zero) begin
         win1_in = '0;
         win2_in = new_col;
      end else begin
         win1_in = win2_ff;
         win2_in = new_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win1_ff <= '0;
         win2_ff <= '0;
      end else if (s1_adv) begin
         win1_ff <= win1_in;
         win2_ff <= win2_in;
      end
   end

   c2dc_kernel u_kernel (
      .win    (kwin),
      .coef   (coef_ff),
      .shift  (shift_ff),
      .result (k_result)
   );

   // ---------------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------------
   always_comb begin
      if (s1_adv && s1_ctl_ff.emit) begin
         out_v_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_v_in = 1'b0;
      end else begin
         out_v_in = out_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_ctl_ff.emit) begin
         out_pix_ff  <= k_result;
         out_last_ff <= s1_ctl_ff.last;
      end
   end

   assign rsp_chan.valid      = out_v_ff;
   assign rsp_chan.pixel_out  = out_pix_ff;
   assign rsp_chan.frame_last = out_last_ff;

endmodule

// ===== rtl/c2dc_checker.sv =====
module c2dc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [c2dc_pkg::PixW-1:0] pixel_out,
   input logic                      frame_last
);

   // a waiting result holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pixel_out) && $stable(frame_last))
      else $error("result changed while stalled");

   // reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // with the result register empty the input side never stalls
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // a fresh result comes from an item accepted before it, via the input stage
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a preceding item");

endmodule

bind clamped_2d_convolution c2dc_checker u_c2dc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .pixel_out  (rsp_chan.pixel_out),
   .frame_last (rsp_chan.frame_last)
);

// ===== tb/conv_checker.sv =====
`timescale 1ns / 100ps

module conv_checker
   import c2dc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   c2dc_req_if                 req_mon,
   c2dc_rsp_if                 rsp_mon,
   input  logic                csr_wr_en,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wr_data,
   output int                  fail_count,
   output int                  pending
);

   typedef struct packed {
      pix_type pixel;
      logic    last;
   } out_pix_type;

   out_pix_type expected_pixels[$];

   // register copies
   logic [GeomW-1:0]  width_reg;
   logic [GeomW-1:0]  height_reg;
   coef_type          kernel_rows;
   logic [ShiftW-1:0] shift_reg;

   // line copies and window
   pix_type    row_above[MaxWidth];
   pix_type    row_above2[MaxWidth];
   window_type win;
   int         col_pos;
   int         row_pos;

   function automatic pix_type weigh(input window_type wnd);
      longint acc;
      longint pv;
      logic signed [CoefW-1:0] k;
      int half;
      acc  = 0;
      half = KernelSize / 2;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (r - 1 < -half || r - 1 > half || c - 1 < -half || c - 1 > half) continue;
            k   = kernel_rows[r][CoefW*c +: CoefW];
            pv  = longint'(wnd[r][c]);
            acc += pv * k;
         end
      end
      if (acc <= 0) return '0;
      acc = acc >>> shift_reg;
      if (acc > PixMax) return pix_type'(PixMax);
      return pix_type'(acc);
   endfunction

   task automatic convolve_item(input pix_type px_in, input logic fl,
                                output logic emit, output out_pix_type res);
      int w, h, x, y;
      pix_type px, up1, up2;
      window_type closing_win;
      logic last;
      w = width_reg;
      h = height_reg;
      if (w < 1) w = 1;
      if (w > MaxWidth) w = MaxWidth;
      if (h < 1) h = 1;
      if (h > MaxHeight) h = MaxHeight;
      x = col_pos;
      y = row_pos;
      if (x >= MaxWidth) x = 0;

      px  = (fl || y >= h) ? '0 : px_in;
      up1 = (y >= 1) ? row_above[x] : '0;
      up2 = (y >= 2) ? row_above2[x] : '0;
      row_above2[x] = up1;
      row_above[x]  = px;

      emit = 1'b0;
      last = 1'b0;
      res  = '0;
      if (x == 0) begin
         // right edge of the row two back, zero column beyond it
         if (y >= 2 && y - 2 < h) begin
            for (int r = 0; r < 3; r++) begin
               closing_win[r][0] = win[r][1];
               closing_win[r][1] = win[r][2];
               closing_win[r][2] = '0;
            end
            emit      = 1'b1;
            res.pixel = weigh(closing_win);
            last      = (y - 2 == h - 1);
         end
         for (int r = 0; r < 3; r++) begin
            win[r][0] = '0;
            win[r][1] = '0;
         end
      end else begin
         for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
         end
      end
      win[0][2] = up2;
      win[1][2] = up1;
      win[2][2] = px;

      if (x != 0 && y >= 1 && y - 1 < h) begin
         emit      = 1'b1;
         res.pixel = weigh(win);
      end
      res.last = last;

      if (last) begin
         col_pos = 0;
         row_pos = 0;
         win     = '0;
      end else if (x + 1 >= w) begin
         col_pos = 0;
         row_pos = (y + 1) % 2048;
      end else begin
         col_pos = x + 1;
         row_pos = y;
      end
   endtask

   always @(posedge clock) begin : check_proc
      logic        emit;
      out_pix_type res;
      out_pix_type want;
      if (reset) begin
         width_reg   = GeomW'(WidthReset);
         height_reg  = GeomW'(HeightReset);
         kernel_rows = '0;
         shift_reg   = '0;
         win         = '0;
         col_pos     = 0;
         row_pos     = 0;
         fail_count  = 0;
         for (int i = 0; i < MaxWidth; i++) begin
            row_above[i]  = '0;
            row_above2[i] = '0;
         end
         expected_pixels.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_IMAGE_WIDTH:     width_reg      = csr_wr_data[GeomW-1:0];
               CSR_IMAGE_HEIGHT:    height_reg     = csr_wr_data[GeomW-1:0];
               CSR_COEF_TOP_ROW:    kernel_rows[0] = csr_wr_data[CoefRowW-1:0];
               CSR_COEF_MID_ROW:    kernel_rows[1] = csr_wr_data[CoefRowW-1:0];
               CSR_COEF_BOTTOM_ROW: kernel_rows[2] = csr_wr_data[CoefRowW-1:0];
               CSR_FRAC_SHIFT:      shift_reg      = csr_wr_data[ShiftW-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            convolve_item(req_mon.pixel_in, req_mon.fill, emit, res);
            if (emit) expected_pixels.push_back(res);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected pixel, expected none, actual pixel_out %0d frame_last %0b",
                        $time, rsp_mon.pixel_out, rsp_mon.frame_last);
               fail_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_mon.pixel_out !== want.pixel) begin
                  $display("%0t: pixel_out expected %0d, actual %0d",
                           $time, want.pixel, rsp_mon.pixel_out);
                  fail_count++;
               end
               if (rsp_mon.frame_last !== want.last) begin
                  $display("%0t: frame_last expected %0b, actual %0b",
                           $time, want.last, rsp_mon.frame_last);
                  fail_count++;
               end
            end
         end
      end
      pending <= expected_pixels.size();
   end

endmodule

// ===== tb/clamped_2d_convolution_tb.sv =====
`timescale 1ns / 100ps

module clamped_2d_convolution_tb;
   import c2dc_pkg::*;

   // cycles with no movement on either channel before the run is declared hung
   localparam int IdleLimit   = 2000;
   localparam int RandomItems = 1050;
   localparam int FixedShift  = 10;
   localparam int FixedOne    = 1024;

   // flavors of kernel for random frames
   typedef enum int {
      KERN_SMALL_INT,
      KERN_FIXED,
      KERN_RAW,
      KERN_EXTREME
   } kern_mode_type;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wr_data;

   int fail_count;
   int pending;      // results still owed by the block, registered by the checker
   int frame_w;      // effective geometry of the frame being sent
   int frame_h;
   int sent_items;
   int idle_cycles;

   c2dc_req_if pix_req_if ();
   c2dc_rsp_if pix_rsp_if ();

   clamped_2d_convolution u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (pix_req_if),
      .rsp_chan    (pix_rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   conv_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (pix_req_if),
      .rsp_mon     (pix_rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly back-to-back, some short gaps, a rare long one
   function automatic int pick_gap(input bit burst);
      int r;
      if (burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // lean on the rails so the clamp and the zero/full bits see plenty of use
   function automatic pix_type pick_pixel();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return pix_type'(PixMax);
      return pix_type'($urandom_range(0, PixMax));
   endfunction

   function automatic logic [CoefRowW-1:0] pick_coef_row(input kern_mode_type mode);
      logic [CoefRowW-1:0] row;
      int t;
      for (int c = 0; c < 3; c++) begin
         case (mode)
            KERN_SMALL_INT: t = int'($urandom_range(0, 8)) - 4;
            // real weights around -0.75 .. 1.25 scaled by 1024
            KERN_FIXED:     t = int'($urandom_range(0, 2 * FixedOne)) - 768;
            KERN_RAW:       t = int'($urandom_range(0, 65535));
            default: begin
               case ($urandom_range(0, 3))
                  0:       t = 32767;
                  1:       t = -32768;
                  2:       t = 0;
                  default: t = -1;
               endcase
            end
         endcase
         row[CoefW*c +: CoefW] = t[CoefW-1:0];
      end
      return row;
   endfunction

   function automatic int pick_shift(input kern_mode_type mode);
      case (mode)
         KERN_SMALL_INT: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
         KERN_FIXED:     return FixedShift;
         KERN_RAW:       return $urandom_range(0, 15);
         default:        return ($urandom_range(0, 1) == 1) ? 15 : 0;
      endcase
   endfunction

   // one item: optional gap with valid low, then hold until accepted
   task automatic push(input pix_type px, input logic fl, input int gap);
      if (gap > 0) begin
         pix_req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pix_req_if.valid    <= 1'b1;
      pix_req_if.pixel_in <= px;
      pix_req_if.fill     <= fl;
      @(posedge clock);
      while (!pix_req_if.ready) @(posedge clock);
      sent_items++;
   endtask

   // stop sending, let every owed result come out, then keep the clock running
   // since the items of a first row leave no result behind
   task automatic settle();
      pix_req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CsrDataW-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   // all six registers; now and then junk rides in the unused upper bits
   task automatic program_frame(input int raw_w, input int raw_h,
                                input logic [CoefRowW-1:0] top_row,
                                input logic [CoefRowW-1:0] mid_row,
                                input logic [CoefRowW-1:0] bot_row,
                                input int shift);
      logic [CsrDataW-1:0] junk;
      junk = CsrDataW'({$urandom, $urandom});
      if ($urandom_range(0, 7) != 0) junk = '0;
      write_reg(CSR_IMAGE_WIDTH, {junk[CsrDataW-1:GeomW], raw_w[GeomW-1:0]});
      write_reg(CSR_IMAGE_HEIGHT, {junk[CsrDataW-1:GeomW], raw_h[GeomW-1:0]});
      write_reg(CSR_COEF_TOP_ROW, top_row);
      write_reg(CSR_COEF_MID_ROW, mid_row);
      write_reg(CSR_COEF_BOTTOM_ROW, bot_row);
      write_reg(CSR_FRAC_SHIFT, {junk[CsrDataW-1:ShiftW], shift[ShiftW-1:0]});
      csr_wr_en <= 1'b0;
      // zero behaves as one, oversize as the maximum
      frame_w = (raw_w == 0) ? 1 : (raw_w > MaxWidth) ? MaxWidth : raw_w;
      frame_h = (raw_h == 0) ? 1 : (raw_h > MaxHeight) ? MaxHeight : raw_h;
   endtask

   // full frame plus width+1 flush items; a noisy frame slips fill items
   // into the picture and real pixels into the flush
   task automatic run_frame(input bit noisy, input bit pause_mid);
      bit burst;
      int n;
      burst = ($urandom_range(0, 3) == 0);
      n     = frame_w * frame_h;
      for (int i = 0; i < n; i++) begin
         push(pick_pixel(), noisy && $urandom_range(0, 19) == 0, pick_gap(burst));
         if (pause_mid && i == n / 2) settle();
      end
      for (int i = 0; i <= frame_w; i++)
         push(pick_pixel(), !(noisy && $urandom_range(0, 9) == 0), pick_gap(burst));
   endtask

   // result side: random back-pressure, with long stretches of none
   initial begin : rsp_drive
      int stall;
      int run_len;
      pix_rsp_if.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = pick_gap(1'b0);
         if (stall > 0) begin
            pix_rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pix_rsp_if.ready <= 1'b1;
         run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
         repeat (run_len) @(posedge clock);
      end
   end

   // watchdog: nothing moved on either channel for too long
   always @(posedge clock) begin
      if (reset || (pix_req_if.valid && pix_req_if.ready) ||
          (pix_rsp_if.valid && pix_rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int start;
      int frame_no;
      int r;
      int w;
      int h;
      int raw_w;
      int raw_h;
      kern_mode_type mode;

      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_index           <= CSR_IMAGE_WIDTH;
      csr_wr_data         <= '0;
      pix_req_if.valid    <= 1'b0;
      pix_req_if.pixel_in <= '0;
      pix_req_if.fill     <= 1'b0;
      sent_items = 0;
      idle_cycles = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      // largest positive taps, no shift: saturates; a fill inside the
      // picture counts as black, a real pixel inside the flush is ignored
      program_frame(3, 2, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, 0);
      push(8'd255, 1'b0, 0);
      push(8'd0, 1'b0, 0);
      push(8'd255, 1'b0, 1);
      push(8'hAA, 1'b1, 0);
      push(8'd0, 1'b0, 2);
      push(8'd255, 1'b0, 0);
      push(8'h00, 1'b1, 0);
      push(8'hFF, 1'b1, 0);
      push(8'h55, 1'b0, 0);
      push(8'h00, 1'b1, 3);
      settle();

      // most negative taps above, large centre, full shift
      program_frame(2, 2, {3{16'h8000}}, {16'h0000, 16'h7FFF, 16'h0000}, '0, 15);
      repeat (4) push(8'd255, 1'b0, pick_gap(1'b0));
      repeat (3) push(8'd0, 1'b1, pick_gap(1'b0));
      settle();

      // zero geometry acts as a 1x1 frame; identity kernel in fixed point
      program_frame(0, 0, '0, {16'd0, 16'(FixedOne), 16'd0}, '0, FixedShift);
      push(8'd200, 1'b0, 0);
      push(8'd0, 1'b1, 0);
      push(8'd0, 1'b1, 0);
      settle();

      // --- geometry corners ---
      // height cut below the current row mid-frame: rows past it give no
      // results and read as black; raising it again lets the frame close
      program_frame(1, 6, pick_coef_row(KERN_SMALL_INT), pick_coef_row(KERN_SMALL_INT),
                    pick_coef_row(KERN_SMALL_INT), 0);
      repeat (4) push(pick_pixel(), 1'b0, pick_gap(1'b0));
      settle();
      write_reg(CSR_IMAGE_HEIGHT, CsrDataW'(2));
      csr_wr_en <= 1'b0;
      repeat (2) push(pick_pixel(), 1'b0, pick_gap(1'b0));
      settle();
      write_reg(CSR_IMAGE_HEIGHT, CsrDataW'(6));
      csr_wr_en <= 1'b0;
      repeat (2) push(pick_pixel(), 1'b1, pick_gap(1'b0));
      settle();

      // width narrowed mid-frame: column wraps at the new width
      program_frame(5, 4, pick_coef_row(KERN_SMALL_INT), pick_coef_row(KERN_SMALL_INT),
                    pick_coef_row(KERN_SMALL_INT), 0);
      repeat (7) push(pick_pixel(), 1'b0, pick_gap(1'b0));
      settle();
      write_reg(CSR_IMAGE_WIDTH, CsrDataW'(3));
      csr_wr_en <= 1'b0;
      repeat (7) push(pick_pixel(), 1'b0, pick_gap(1'b0));
      repeat (4) push(pick_pixel(), 1'b1, pick_gap(1'b0));
      settle();

      // --- random frames, mostly small ---
      start    = sent_items;
      frame_no = 0;
      while (sent_items - start < RandomItems) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 6);
         end else if (r < 95) begin
            w = $urandom_range(9, 40);
            h = $urandom_range(1, 12);
         end else begin
            w = $urandom_range(41, 120);
            h = $urandom_range(1, 4);
         end
         raw_w = (w == 1 && $urandom_range(0, 1) == 1) ? 0 : w;
         raw_h = (h == 1 && $urandom_range(0, 1) == 1) ? 0 : h;
         mode  = kern_mode_type'($urandom_range(0, 3));
         program_frame(raw_w, raw_h, pick_coef_row(mode), pick_coef_row(mode),
                       pick_coef_row(mode), pick_shift(mode));
         // the third frame also drains completely halfway through
         run_frame($urandom_range(0, 1) == 1, frame_no == 2);
         settle();
         frame_no++;
      end

      // everything accepted: drain, linger for stray results, then judge
      settle();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
